// File: design/bq_pkg.sv
// shared types and codes for the direct form ii biquad
`timescale 1ns / 1ps
`default_nettype none

package bq_pkg;

	localparam int NUM_COEFS = 5;
	localparam int CIDX_W    = 3;
	localparam int DELAY_FRAC = 8;

	typedef enum logic [CIDX_W-1:0] {
		COEF_B0 = 3'd0,
		COEF_B1 = 3'd1,
		COEF_B2 = 3'd2,
		COEF_A1 = 3'd3,
		COEF_A2 = 3'd4
	} coef_idx_t;

	typedef enum logic [1:0] {
		DSEL_W1,
		DSEL_W2,
		DSEL_W
	} dsel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_X,
		ACC_SUB,
		ACC_ADD,
		ACC_LOAD_P
	} acc_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FB1,
		ST_FB2,
		ST_FB3,
		ST_WSAT,
		ST_FF0,
		ST_FF1,
		ST_FF2,
		ST_FF3,
		ST_OUT
	} state_t;

	typedef struct packed {
		coef_idx_t csel;
		dsel_t     dsel;
		acc_op_t   acc_op;
		logic      w_en;
		logic      y_en;
	} ctrl_t;

endpackage

`default_nettype wire

// File: design/bq_seq.sv
// sequencer that steps the shared multiplier through the five products
`timescale 1ns / 1ps
`default_nettype none

module bq_seq
	import bq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  wire logic  m_tready,
	output ctrl_t      ctrl
);

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.y_en) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		ctrl.csel   = COEF_B0;
		ctrl.dsel   = DSEL_W;
		ctrl.acc_op = ACC_HOLD;
		ctrl.w_en   = 1'b0;
		ctrl.y_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ctrl.acc_op = ACC_LOAD_X;
					state_d     = ST_FB1;
				end
			end
			ST_FB1: begin
				ctrl.csel = COEF_A1;
				ctrl.dsel = DSEL_W1;
				state_d   = ST_FB2;
			end
			ST_FB2: begin
				ctrl.csel   = COEF_A2;
				ctrl.dsel   = DSEL_W2;
				ctrl.acc_op = ACC_SUB;
				state_d     = ST_FB3;
			end
			ST_FB3: begin
				ctrl.acc_op = ACC_SUB;
				state_d     = ST_WSAT;
			end
			ST_WSAT: begin
				ctrl.w_en = 1'b1;
				state_d   = ST_FF0;
			end
			ST_FF0: begin
				ctrl.csel = COEF_B0;
				ctrl.dsel = DSEL_W;
				state_d   = ST_FF1;
			end
			ST_FF1: begin
				ctrl.csel   = COEF_B1;
				ctrl.dsel   = DSEL_W1;
				ctrl.acc_op = ACC_LOAD_P;
				state_d     = ST_FF2;
			end
			ST_FF2: begin
				ctrl.csel   = COEF_B2;
				ctrl.dsel   = DSEL_W2;
				ctrl.acc_op = ACC_ADD;
				state_d     = ST_FF3;
			end
			ST_FF3: begin
				ctrl.acc_op = ACC_ADD;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					ctrl.y_en = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/bq_datapath.sv
// coefficient registers, shared multiplier, accumulator, rounding and saturation
`timescale 1ns / 1ps
`default_nettype none

module bq_datapath
	import bq_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ctrl_t                             ctrl,
	input  wire logic signed [SAMPLE_WIDTH-1:0]    x,
	input  wire logic                              cfg_we,
	input  wire logic [CIDX_W-1:0]                 cfg_index,
	input  wire logic [COEF_FRAC_BITS+1:0]         cfg_data,
	output logic signed [SAMPLE_WIDTH-1:0]         y,
	output logic                                   clipped
);

	localparam int CW    = COEF_FRAC_BITS + 2;
	localparam int DW    = SAMPLE_WIDTH + DELAY_FRAC;
	localparam int PW    = CW + DW;
	localparam int ACC_W = SAMPLE_WIDTH + COEF_FRAC_BITS + 12;
	localparam int YS    = COEF_FRAC_BITS + DELAY_FRAC;
	localparam int RW    = ACC_W - COEF_FRAC_BITS;
	localparam int YRW   = ACC_W - YS;

	localparam logic [ACC_W-1:0] W_RND =
		{{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
	localparam logic [ACC_W-1:0] Y_RND = {{(ACC_W-YS){1'b0}}, 1'b1, {(YS-1){1'b0}}};
	localparam logic [CW-1:0] COEF_ONE = {2'b01, {COEF_FRAC_BITS{1'b0}}};

	logic signed [CW-1:0]    coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
	logic signed [DW-1:0]    delay_one_q, delay_two_q, w_q;
	logic signed [PW-1:0]    prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    hit_q;
	logic signed [SAMPLE_WIDTH-1:0] y_q;
	logic                    clipped_q;

	logic signed [CW-1:0]    coef_mux;
	logic signed [DW-1:0]    delay_mux;
	logic signed [ACC_W-1:0] x_ext, prod_ext;
	logic [ACC_W-1:0]        w_sum, y_sum;
	logic [RW-1:0]           w_r;
	logic [YRW-1:0]          y_r;
	logic                    w_ovf, y_ovf;
	logic [DW-1:0]           w_sat;
	logic [SAMPLE_WIDTH-1:0] y_sat;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0_q <= COEF_ONE;
			coef_b1_q <= '0;
			coef_b2_q <= '0;
			coef_a1_q <= '0;
			coef_a2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				COEF_B0: coef_b0_q <= cfg_data;
				COEF_B1: coef_b1_q <= cfg_data;
				COEF_B2: coef_b2_q <= cfg_data;
				COEF_A1: coef_a1_q <= cfg_data;
				COEF_A2: coef_a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ctrl.csel)
			COEF_B0: coef_mux = coef_b0_q;
			COEF_B1: coef_mux = coef_b1_q;
			COEF_B2: coef_mux = coef_b2_q;
			COEF_A1: coef_mux = coef_a1_q;
			COEF_A2: coef_mux = coef_a2_q;
			default: coef_mux = coef_b0_q;
		endcase
		case (ctrl.dsel)
			DSEL_W1: delay_mux = delay_one_q;
			DSEL_W2: delay_mux = delay_two_q;
			DSEL_W:  delay_mux = w_q;
			default: delay_mux = w_q;
		endcase
	end

	assign x_ext    = {{(ACC_W-SAMPLE_WIDTH-YS){x[SAMPLE_WIDTH-1]}}, x, {YS{1'b0}}};
	assign prod_ext = {{(ACC_W-PW){prod_q[PW-1]}}, prod_q};

	// round half up, then clamp
	assign w_sum = acc_q + W_RND;
	assign w_r   = w_sum[ACC_W-1:COEF_FRAC_BITS];
	assign w_ovf = !((&w_r[RW-1:DW-1]) || !(|w_r[RW-1:DW-1]));
	assign w_sat = w_ovf ? {w_r[RW-1], {(DW-1){~w_r[RW-1]}}} : w_r[DW-1:0];

	assign y_sum = acc_q + Y_RND;
	assign y_r   = y_sum[ACC_W-1:YS];
	assign y_ovf = !((&y_r[YRW-1:SAMPLE_WIDTH-1]) || !(|y_r[YRW-1:SAMPLE_WIDTH-1]));
	assign y_sat = y_ovf ? {y_r[YRW-1], {(SAMPLE_WIDTH-1){~y_r[YRW-1]}}}
	                     : y_r[SAMPLE_WIDTH-1:0];

	always_ff @(posedge clk) begin
		prod_q <= coef_mux * delay_mux;
		case (ctrl.acc_op)
			ACC_LOAD_X: acc_q <= x_ext;
			ACC_SUB:    acc_q <= acc_q - prod_ext;
			ACC_ADD:    acc_q <= acc_q + prod_ext;
			ACC_LOAD_P: acc_q <= prod_ext;
			default:    acc_q <= acc_q;
		endcase
		if (ctrl.w_en) begin
			w_q   <= w_sat;
			hit_q <= w_ovf;
		end
		if (ctrl.y_en) begin
			y_q       <= y_sat;
			clipped_q <= hit_q | y_ovf;
		end
	end

	// delay line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_one_q <= '0;
			delay_two_q <= '0;
		end else if (ctrl.y_en) begin
			delay_two_q <= delay_one_q;
			delay_one_q <= w_q;
		end
	end

	assign y       = y_q;
	assign clipped = clipped_q;

endmodule

`default_nettype wire

// File: design/biquad_lowpass_df2_core.sv
// top level of the direct form ii biquad filter
// Second-order IIR biquad, direct form II: w = x - a1*w1 - a2*w2, then
// y = b0*w + b1*w1 + b2*w2, with w held at 8 fractional bits, both sums
// rounded half up and saturated; m_tuser flags any saturation of the item.
// Coefficients are signed Q2.F words written through cfg_we/cfg_index/cfg_data
// (index 0..4 = b0, b1, b2, a1, a2); the user must write them only while the
// block is idle; the block itself does not enforce it. A single multiplier
// with a product register is stepped through the five products; the WSAT and
// OUT states round and clamp w and y. The result waits in an output register,
// and a new item is taken while it waits; the block stalls only if the next
// result is ready before the previous one has been taken.
`timescale 1ns / 1ps
`default_nettype none

module biquad_lowpass_df2_core
	import bq_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// sample_in
	input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// sample_out
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       m_tdata,
	// clipped
	output logic                                    m_tuser,
	input  wire logic                               cfg_we,
	input  wire logic [CIDX_W-1:0]                  cfg_index,
	input  wire logic [COEF_FRAC_BITS+1:0]          cfg_data
);

	localparam int TW = ((SAMPLE_WIDTH + 7) / 8) * 8;

	ctrl_t                          ctrl;
	logic signed [SAMPLE_WIDTH-1:0] y;

	bq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctrl     (ctrl)
	);

	bq_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.x         (s_tdata[SAMPLE_WIDTH-1:0]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.y         (y),
		.clipped   (m_tuser)
	);

	assign m_tdata = {{(TW-SAMPLE_WIDTH){1'b0}}, y};

`ifndef SYNTH
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
		else $error("result appeared right after acceptance");

	a_result_loads_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.y_en |=> m_tvalid)
		else $error("result load did not raise m_tvalid");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.w_en || ctrl.acc_op == ACC_SUB || ctrl.acc_op == ACC_ADD) |-> !s_tready)
		else $error("ready while an item is in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !ctrl.y_en)
		else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire
